/* sv/xoloc_pkg.sv */
// shared types, constants and lookup functions for the crossover locator
// used by xoloc_tracker, crossover_locator_core and xoloc_checker; no dependencies
package xoloc_pkg;

    localparam int MAX_MARKERS   = 4096;
    localparam int MARKER_W      = $clog2(MAX_MARKERS);
    localparam int POSITION_BITS = 24;
    localparam int GENO_W        = 3;
    localparam int FIELD_W       = 13;

    localparam logic [MARKER_W-1:0] MARKER_LAST = MARKER_W'(MAX_MARKERS - 1);
    localparam logic [FIELD_W-1:0]  TYPED_MAX   = {FIELD_W{1'b1}};

    // floor(x/3) for x < 2**(POSITION_BITS+2): multiply by ceil(2**k/3), shift by k
    localparam int               DIV3_SHIFT = POSITION_BITS + 4;
    localparam int               DIV3_W     = DIV3_SHIFT - 1;
    localparam logic [DIV3_W-1:0] DIV3_MUL  = DIV3_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    // configuration register map
    localparam logic REG_CROSS_TYPE = 1'b0;
    localparam logic CROSS_BACK     = 1'b0;
    localparam logic CROSS_INTER    = 1'b1;

    // bus widths and field offsets
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 128;
    localparam int PADDR_W   = 3;

    localparam int OFS_LOC   = 0;
    localparam int OFS_LPOS  = OFS_LOC + POSITION_BITS;
    localparam int OFS_RPOS  = OFS_LPOS + POSITION_BITS;
    localparam int OFS_LIDX  = OFS_RPOS + POSITION_BITS;
    localparam int OFS_RIDX  = OFS_LIDX + FIELD_W;
    localparam int OFS_XNUM  = OFS_RIDX + FIELD_W;
    localparam int OFS_TBTW  = OFS_XNUM + FIELD_W;
    localparam int OUT_USED  = OFS_TBTW + FIELD_W;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [FIELD_W-1:0]       field_t;

    // one detected crossover event, one or two result beats
    typedef struct packed {
        logic   valid;
        logic   two;
        pos_t   left_pos;
        pos_t   right_pos;
        field_t left_idx;
        field_t right_idx;
        field_t ordinal;
        field_t between;
    } job_t;

    function automatic field_t one_based(input logic [MARKER_W-1:0] i);
        return FIELD_W'(i) + FIELD_W'(1);
    endfunction

    // intercross: number of crossovers for a move from cur to g
    function automatic logic [1:0] ic_count(input logic [GENO_W-1:0] g,
                                            input logic [GENO_W-1:0] cur);
        logic [1:0] n;
        n = 2'd0;
        case ({g, cur})
            {3'd1, 3'd2}, {3'd1, 3'd5}, {3'd2, 3'd1}, {3'd2, 3'd3},
            {3'd3, 3'd2}, {3'd3, 3'd4}, {3'd4, 3'd3}, {3'd5, 3'd1}: n = 2'd1;
            {3'd1, 3'd3}, {3'd3, 3'd1}: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // intercross: genotype remembered after a move from cur to g
    function automatic logic [GENO_W-1:0] ic_next(input logic [GENO_W-1:0] g,
                                                  input logic [GENO_W-1:0] cur);
        logic [GENO_W-1:0] nx;
        nx = cur;
        if (cur == 3'd0) begin
            nx = 3'd0;
        end else if (cur inside {[3'd1:3'd5]}) begin
            case (g)
                3'd1, 3'd2, 3'd3: nx = g;
                3'd4: nx = (cur == 3'd1) ? 3'd1 : ((cur == 3'd4) ? 3'd4 : 3'd2);
                3'd5: nx = (cur == 3'd3) ? 3'd3 : ((cur == 3'd5) ? 3'd5 : 3'd2);
                default: nx = cur;
            endcase
        end
        return nx;
    endfunction

endpackage

/* sv/xoloc_tracker.sv */
// per-individual marker tracking: remembered genotype, counters, crossover detection
// depends on xoloc_pkg
module xoloc_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_accept,
    input  logic [xoloc_pkg::GENO_W-1:0]        genotype,
    input  xoloc_pkg::pos_t                     position,
    input  logic                                first_marker,
    input  logic                                cross_type,
    output xoloc_pkg::job_t                     job
);

    logic [xoloc_pkg::GENO_W-1:0]   cur_gen_reg, cur_gen_next;
    xoloc_pkg::pos_t                cur_pos_reg, cur_pos_next;
    logic [xoloc_pkg::MARKER_W-1:0] cur_idx_reg, cur_idx_next;
    logic [xoloc_pkg::MARKER_W-1:0] mark_cnt_reg, mark_cnt_next;
    xoloc_pkg::field_t              xo_cnt_reg, xo_cnt_next;
    xoloc_pkg::field_t              typed_cnt_reg, typed_cnt_next;

    logic [xoloc_pkg::MARKER_W-1:0] idx;
    xoloc_pkg::field_t              typed_inc;
    logic [1:0]                     nxo;
    logic [xoloc_pkg::GENO_W-1:0]   next_gen;

    always_comb begin
        cur_gen_next   = cur_gen_reg;
        cur_pos_next   = cur_pos_reg;
        cur_idx_next   = cur_idx_reg;
        mark_cnt_next  = mark_cnt_reg;
        xo_cnt_next    = xo_cnt_reg;
        typed_cnt_next = typed_cnt_reg;

        idx       = (mark_cnt_reg == xoloc_pkg::MARKER_LAST) ? '0 : mark_cnt_reg + 1'b1;
        typed_inc = (typed_cnt_reg < xoloc_pkg::TYPED_MAX) ? typed_cnt_reg + 1'b1
                                                           : typed_cnt_reg;
        if (cross_type == xoloc_pkg::CROSS_INTER) begin
            nxo      = xoloc_pkg::ic_count(genotype, cur_gen_reg);
            next_gen = xoloc_pkg::ic_next(genotype, cur_gen_reg);
        end else begin
            nxo      = 2'd1;
            next_gen = genotype;
        end

        job.valid     = 1'b0;
        job.two       = (nxo == 2'd2);
        job.left_pos  = cur_pos_reg;
        job.right_pos = position;
        job.left_idx  = xoloc_pkg::one_based(cur_idx_reg);
        job.right_idx = xoloc_pkg::one_based(idx);
        job.ordinal   = xo_cnt_reg;
        job.between   = (xo_cnt_reg == '0) ? '0 : typed_cnt_reg;

        if (in_accept) begin
            if (first_marker) begin
                cur_gen_next   = genotype;
                cur_pos_next   = position;
                cur_idx_next   = '0;
                mark_cnt_next  = '0;
                xo_cnt_next    = '0;
                typed_cnt_next = (genotype != '0) ? xoloc_pkg::field_t'(1) : '0;
            end else begin
                mark_cnt_next = idx;
                if (cur_gen_reg == '0) begin
                    // nothing typed yet: take this marker as the reference
                    cur_gen_next = genotype;
                    cur_pos_next = position;
                    cur_idx_next = idx;
                    if (genotype != '0) begin
                        typed_cnt_next = typed_inc;
                    end
                end else if (genotype == '0) begin
                    // untyped marker only advances the index
                end else if (genotype == cur_gen_reg) begin
                    cur_pos_next   = position;
                    cur_idx_next   = idx;
                    typed_cnt_next = typed_inc;
                end else begin
                    job.valid    = (nxo != 2'd0);
                    cur_gen_next = next_gen;
                    cur_pos_next = position;
                    cur_idx_next = idx;
                    if (nxo != 2'd0) begin
                        xo_cnt_next    = xo_cnt_reg + xoloc_pkg::FIELD_W'(nxo);
                        typed_cnt_next = xoloc_pkg::field_t'(1);
                    end else begin
                        typed_cnt_next = typed_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_gen_reg   <= '0;
            cur_pos_reg   <= '0;
            cur_idx_reg   <= '0;
            mark_cnt_reg  <= '0;
            xo_cnt_reg    <= '0;
            typed_cnt_reg <= '0;
        end else begin
            cur_gen_reg   <= cur_gen_next;
            cur_pos_reg   <= cur_pos_next;
            cur_idx_reg   <= cur_idx_next;
            mark_cnt_reg  <= mark_cnt_next;
            xo_cnt_reg    <= xo_cnt_next;
            typed_cnt_reg <= typed_cnt_next;
        end
    end

endmodule

/* sv/crossover_locator_core.sv */
// crossover locator top level: stream ports, config register, result beat stage
// depends on xoloc_pkg and xoloc_tracker
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------------
//  s_       | in  | one marker: genotype, position; tlast = first marker of individual
//  m_       | out | one crossover: location, flanks, indices, ordinal, typed count
//  apb      | in  | cross_type register at byte address 0
//
// an accepted marker's crossover event is registered in a job register; its result beats
// leave from there through the output register, one per cycle while m_tready is high
// markers that cause no crossover flow at one per cycle with no extra cost while the job register is empty
// a marker that causes two crossovers holds s_tready low until its second beat moves out
// s_tready is high while the job register is empty or its last beat moves out, so a stalled
// result with a job behind it holds the input; reset is synchronous, clears all but m_tdata, m_tlast
module crossover_locator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // marker input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [xoloc_pkg::S_TDATA_W-1:0]    s_tdata,   // genotype[2:0], position[26:3], zero fill
    input  logic                               s_tlast,   // first_marker
    // crossover output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xoloc_pkg::M_TDATA_W-1:0]    m_tdata,   // location, left_position,
                                                          // right_position, left_index,
                                                          // right_index, crossover_number,
                                                          // typed_between, zero fill
    output logic                               m_tlast,   // last result of this marker
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [xoloc_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int PB = xoloc_pkg::POSITION_BITS;

    logic                         cross_type_reg;
    xoloc_pkg::job_t              job;
    xoloc_pkg::job_t              job_reg, job_next;
    logic                         phase_reg, phase_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [xoloc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;

    logic                         s_accept;
    logic                         out_load;
    logic                         beat_fire;
    logic                         job_end;
    logic                         cfg_write;

    // location arithmetic
    logic [PB:0]                  half_sum;
    logic [PB+1:0]                third_sum;
    logic [PB+1+xoloc_pkg::DIV3_W:0] third_prod;
    xoloc_pkg::pos_t              location;
    xoloc_pkg::field_t            beat_ordinal;
    xoloc_pkg::field_t            beat_between;
    logic                         beat_last;

    // apb register: always ready, write on access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == xoloc_pkg::REG_CROSS_TYPE) ? {31'd0, cross_type_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cross_type_reg <= xoloc_pkg::CROSS_BACK;
        end else if (cfg_write && paddr[2] == xoloc_pkg::REG_CROSS_TYPE) begin
            cross_type_reg <= pwdata[0];
        end
    end

    // handshake: output register frees when empty or taken; job ends on its last beat
    assign out_load  = !m_tvalid_reg || m_tready;
    assign beat_fire = job_reg.valid && out_load;
    assign job_end   = beat_fire && (!job_reg.two || phase_reg);
    assign s_tready  = !job_reg.valid || job_end;
    assign s_accept  = s_tvalid && s_tready;

    xoloc_tracker u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (s_accept),
        .genotype     (s_tdata[2:0]),
        .position     (s_tdata[3 +: PB]),
        .first_marker (s_tlast),
        .cross_type   (cross_type_reg),
        .job          (job)
    );

    // location: midpoint for a single crossover, 2/3 then 1/3 point for a pair
    always_comb begin
        half_sum   = {1'b0, job_reg.left_pos} + {1'b0, job_reg.right_pos};
        if (phase_reg) begin
            third_sum = {1'b0, job_reg.left_pos, 1'b0} + {2'b00, job_reg.right_pos};
        end else begin
            third_sum = {2'b00, job_reg.left_pos} + {1'b0, job_reg.right_pos, 1'b0};
        end
        third_prod = third_sum * xoloc_pkg::DIV3_MUL;
        if (job_reg.two) begin
            location = third_prod[xoloc_pkg::DIV3_SHIFT +: PB];
        end else begin
            location = half_sum[PB:1];
        end
        // the second of a pair shares the interval, so nothing typed in between
        beat_ordinal = phase_reg ? job_reg.ordinal + 1'b1 : job_reg.ordinal;
        beat_between = phase_reg ? '0 : job_reg.between;
        beat_last    = !job_reg.two || phase_reg;
    end

    always_comb begin
        job_next      = job_reg;
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (s_accept) begin
            job_next   = job;
            phase_next = 1'b0;
        end else if (job_end) begin
            job_next.valid = 1'b0;
            phase_next     = 1'b0;
        end else if (beat_fire) begin
            phase_next = 1'b1;
        end

        if (out_load) begin
            m_tvalid_next = beat_fire;
            if (beat_fire) begin
                m_tdata_next = '0;
                m_tdata_next[xoloc_pkg::OFS_LOC  +: PB] = location;
                m_tdata_next[xoloc_pkg::OFS_LPOS +: PB] = job_reg.left_pos;
                m_tdata_next[xoloc_pkg::OFS_RPOS +: PB] = job_reg.right_pos;
                m_tdata_next[xoloc_pkg::OFS_LIDX +: xoloc_pkg::FIELD_W] = job_reg.left_idx;
                m_tdata_next[xoloc_pkg::OFS_RIDX +: xoloc_pkg::FIELD_W] = job_reg.right_idx;
                m_tdata_next[xoloc_pkg::OFS_XNUM +: xoloc_pkg::FIELD_W] = beat_ordinal;
                m_tdata_next[xoloc_pkg::OFS_TBTW +: xoloc_pkg::FIELD_W] = beat_between;
                m_tlast_next = beat_last;
            end
        end
    end

    // control state and job register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg      <= '0;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            job_reg      <= job_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload, no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* sv/xoloc_checker.sv */
// port-level checks for crossover_locator_core, bound to every instance
// depends on xoloc_pkg and crossover_locator_core
module xoloc_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [xoloc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tlast
);

    localparam int FW = xoloc_pkg::FIELD_W;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // second beat of a pair follows at once with the next ordinal
    a_pair_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid &&
        m_tdata[xoloc_pkg::OFS_XNUM +: FW] ==
            FW'($past(m_tdata[xoloc_pkg::OFS_XNUM +: FW]) + 1'b1))
        else $error("pair second beat missing or misnumbered");

    // both beats of a pair share the right flank; the second has no typed count
    a_pair_flank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
        m_tdata[xoloc_pkg::OFS_RPOS +: xoloc_pkg::POSITION_BITS] ==
            $past(m_tdata[xoloc_pkg::OFS_RPOS +: xoloc_pkg::POSITION_BITS]) &&
        m_tdata[xoloc_pkg::OFS_TBTW +: FW] == '0)
        else $error("pair beats disagree on flanks or typed count");

    // reset empties the result path and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset left the block busy");

endmodule

bind crossover_locator_core xoloc_checker u_xoloc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/tb_crossover_locator_core.sv */
// self-checking testbench for crossover_locator_core: marker stream in, crossover beats out
// drives the marker and apb ports, predicts every crossover beat and compares; needs xoloc_pkg
module tb_crossover_locator_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef xoloc_pkg::pos_t   pos_t;
    typedef xoloc_pkg::field_t field_t;

    // register map: byte address of each register, plus one address that holds nothing
    localparam logic [xoloc_pkg::PADDR_W-1:0] ADDR_CROSS_TYPE =
        xoloc_pkg::PADDR_W'(4 * int'(xoloc_pkg::REG_CROSS_TYPE));
    localparam logic [xoloc_pkg::PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    localparam int STALL_LIMIT   = 3000;  // cycles with work pending and no beat moving
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 12;    // job register plus output register, with margin
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [2:0] geno;
        pos_t       pos;
        logic       first;
    } marker_t;

    typedef struct packed {
        pos_t   location;
        pos_t   left_pos;
        pos_t   right_pos;
        field_t left_idx;
        field_t right_idx;
        field_t number;
        field_t between;
        logic   last;
    } crossover_t;

    // dut ports
    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [xoloc_pkg::S_TDATA_W-1:0]   s_tdata = '0;   // genotype[2:0], position[26:3], zero fill
    logic                              s_tlast = 1'b0; // first_marker
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [xoloc_pkg::M_TDATA_W-1:0]   m_tdata;        // location, left_position, right_position,
                                                       // left_index, right_index,
                                                       // crossover_number, typed_between, zero fill
    logic                              m_tlast;        // last crossover of this marker
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [xoloc_pkg::PADDR_W-1:0]     paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    crossover_locator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // stimulus and scoreboard bookkeeping
    marker_t    marker_q[$];
    crossover_t expected_crossovers[$];
    int         queued_cnt = 0;
    int         accepted_cnt = 0;
    int         beats_checked = 0;
    int         error_cnt = 0;
    int         stall_cycles = 0;
    logic       s_taken = 1'b0;
    logic       calm = 1'b0;       // no idling on either side
    logic       hold_req = 1'b0;   // asks the receiver for one long hold-off
    int         src_gap = 0;
    int         snk_gap = 0;
    int         hold_cnt = 0;

    // predictor state, mirrors the block's tracking registers
    logic                              cross_mode = xoloc_pkg::CROSS_BACK;
    logic [2:0]                        cur_geno = '0;
    pos_t                              cur_pos = '0;
    logic [xoloc_pkg::MARKER_W-1:0]    cur_idx = '0;
    logic [xoloc_pkg::MARKER_W-1:0]    marker_cnt = '0;
    field_t                            crossovers_seen = '0;
    field_t                            typed_cnt = '0;

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // intercross: how many crossovers a move from cur to g implies
    function automatic logic [1:0] transitions_of(input logic [2:0] g, input logic [2:0] cur);
        logic [1:0] n;
        n = 2'd0;
        case ({g, cur})
            {3'd1, 3'd3}, {3'd3, 3'd1}: n = 2'd2;
            {3'd1, 3'd2}, {3'd1, 3'd5}, {3'd2, 3'd1}, {3'd2, 3'd3},
            {3'd3, 3'd2}, {3'd3, 3'd4}, {3'd4, 3'd3}, {3'd5, 3'd1}: n = 2'd1;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // intercross: genotype remembered after a move from cur to g
    function automatic logic [2:0] genotype_after(input logic [2:0] g, input logic [2:0] cur);
        logic [2:0] nx;
        nx = cur;
        if (cur inside {[3'd1:3'd5]}) begin
            case (g)
                3'd1, 3'd2, 3'd3: nx = g;
                3'd4: nx = (cur == 3'd1 || cur == 3'd4) ? cur : 3'd2;
                3'd5: nx = (cur == 3'd3 || cur == 3'd5) ? cur : 3'd2;
                default: nx = cur;
            endcase
        end else if (cur == 3'd0) begin
            nx = 3'd0;
        end
        return nx;
    endfunction

    function automatic void bump_typed();
        if (typed_cnt != xoloc_pkg::TYPED_MAX)
            typed_cnt = typed_cnt + 1'b1;
    endfunction

    // advance the tracking state by one marker and queue the crossovers it causes
    task automatic predict_crossovers(input marker_t mk);
        logic [1:0]  nxo;
        logic [2:0]  nxt;
        field_t      between;
        field_t      left_one, right_one;
        logic [25:0] lp, rp;
        logic [25:0] near_right, near_left;
        if (mk.first) begin
            cur_geno = mk.geno;
            cur_pos = mk.pos;
            cur_idx = '0;
            marker_cnt = '0;
            crossovers_seen = '0;
            typed_cnt = (mk.geno != 3'd0) ? field_t'(1) : field_t'(0);
            return;
        end
        marker_cnt = marker_cnt + 1'b1;   // wraps at the marker limit
        if (cur_geno == 3'd0) begin
            cur_geno = mk.geno;
            cur_pos = mk.pos;
            cur_idx = marker_cnt;
            if (mk.geno != 3'd0)
                bump_typed();
            return;
        end
        if (mk.geno == 3'd0)
            return;
        if (mk.geno == cur_geno) begin
            cur_pos = mk.pos;
            cur_idx = marker_cnt;
            bump_typed();
            return;
        end
        if (cross_mode == xoloc_pkg::CROSS_BACK) begin
            nxo = 2'd1;
            nxt = mk.geno;
        end else begin
            nxo = transitions_of(mk.geno, cur_geno);
            nxt = genotype_after(mk.geno, cur_geno);
        end
        between = (crossovers_seen == '0) ? field_t'(0) : typed_cnt;
        left_one = field_t'(cur_idx) + field_t'(1);
        right_one = field_t'(marker_cnt) + field_t'(1);
        lp = 26'(cur_pos);
        rp = 26'(mk.pos);
        if (nxo == 2'd1) begin
            expected_crossovers.push_back('{pos_t'((lp + rp) >> 1), cur_pos, mk.pos,
                left_one, right_one, crossovers_seen, between, 1'b1});
        end else if (nxo == 2'd2) begin
            // two crossovers share one interval: the one nearer the right flank comes first
            near_right = (lp + 2 * rp) / 3;
            near_left = (2 * lp + rp) / 3;
            expected_crossovers.push_back('{pos_t'(near_right), cur_pos, mk.pos,
                left_one, right_one, crossovers_seen, between, 1'b0});
            expected_crossovers.push_back('{pos_t'(near_left), cur_pos, mk.pos,
                left_one, right_one, crossovers_seen + 1'b1, field_t'(0), 1'b1});
        end
        if (nxo != 2'd0) begin
            crossovers_seen = crossovers_seen + field_t'(nxo);
            typed_cnt = field_t'(1);
        end else begin
            bump_typed();
        end
        cur_geno = nxt;
        cur_pos = mk.pos;
        cur_idx = marker_cnt;
    endtask

    task automatic flag_error(input string msg);
        error_cnt++;
        if (error_cnt <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // marker driver: new beat at the falling edge once the previous one was taken
    always @(negedge aclk) begin
        marker_t mk;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (src_gap == 0 && !calm && marker_q.size() != 0 && $urandom_range(0, 7) == 0)
                src_gap = $urandom_range(1, 3);
            if (src_gap > 0 || marker_q.size() == 0) begin
                if (src_gap > 0)
                    src_gap--;
                s_tvalid <= 1'b0;
            end else begin
                mk = marker_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(xoloc_pkg::S_TDATA_W - 27){1'b0}}, mk.pos, mk.geno};
                s_tlast <= mk.first;
            end
        end
        s_taken = 1'b0;
    end

    // result receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            snk_gap = $urandom_range(1, 3) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check output beats against the oldest expectation, then predict
    // from the marker beat taken at this edge; also runs the stall watchdog
    always @(posedge aclk) begin
        crossover_t got, want;
        logic       moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                beats_checked++;
                got.location  = m_tdata[xoloc_pkg::OFS_LOC  +: xoloc_pkg::POSITION_BITS];
                got.left_pos  = m_tdata[xoloc_pkg::OFS_LPOS +: xoloc_pkg::POSITION_BITS];
                got.right_pos = m_tdata[xoloc_pkg::OFS_RPOS +: xoloc_pkg::POSITION_BITS];
                got.left_idx  = m_tdata[xoloc_pkg::OFS_LIDX +: xoloc_pkg::FIELD_W];
                got.right_idx = m_tdata[xoloc_pkg::OFS_RIDX +: xoloc_pkg::FIELD_W];
                got.number    = m_tdata[xoloc_pkg::OFS_XNUM +: xoloc_pkg::FIELD_W];
                got.between   = m_tdata[xoloc_pkg::OFS_TBTW +: xoloc_pkg::FIELD_W];
                got.last      = m_tlast;
                if (expected_crossovers.size() == 0) begin
                    flag_error($sformatf("beat with nothing expected: loc %h l %h r %h",
                        got.location, got.left_pos, got.right_pos));
                end else begin
                    want = expected_crossovers.pop_front();
                    if (got !== want)
                        flag_error($sformatf({"exp loc %h lpos %h rpos %h lidx %0d ridx %0d ",
                            "num %0d btw %0d last %b / got loc %h lpos %h rpos %h lidx %0d ",
                            "ridx %0d num %0d btw %0d last %b"},
                            want.location, want.left_pos, want.right_pos, want.left_idx,
                            want.right_idx, want.number, want.between, want.last,
                            got.location, got.left_pos, got.right_pos, got.left_idx,
                            got.right_idx, got.number, got.between, got.last));
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                s_taken = 1'b1;
                accepted_cnt++;
                predict_crossovers('{s_tdata[2:0], s_tdata[26:3], s_tlast});
            end
        end
        if (moved || (queued_cnt == accepted_cnt && expected_crossovers.size() == 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d beats still expected",
                stall_cycles, expected_crossovers.size());
            $display("FAIL crossover_locator_core");
            $finish;
        end
    end

    task automatic push_marker(input logic [2:0] g, input pos_t p, input logic first);
        marker_q.push_back('{g, p, first});
        queued_cnt++;
    endtask

    // wait for all markers taken and all beats seen, then let the pipeline settle
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || expected_crossovers.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_reg(input logic [xoloc_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_CROSS_TYPE)
            cross_mode = data[0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // read cross_type back and compare with the predictor's copy
    task automatic check_cross_type();
        logic [31:0] value;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_CROSS_TYPE;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        value = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (value[0] !== cross_mode)
            flag_error($sformatf("cross_type read %b, expected %b", value[0], cross_mode));
    endtask

    // genotype for the next marker: runs of the same code, untyped gaps, stray codes
    function automatic logic [2:0] pick_genotype(input logic [2:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && prev != 3'd0)
            return prev;
        if (r < 47)
            return 3'd0;
        if (r < 55)
            return 3'($urandom_range(0, 7));
        if (cross_mode == xoloc_pkg::CROSS_BACK)
            return 3'($urandom_range(1, 2));
        return 3'($urandom_range(1, 5));
    endfunction

    // one individual: first marker, then markers along the map with mostly rising positions
    task automatic gen_individual(input int len);
        logic [2:0] g;
        logic [2:0] typed_prev;
        pos_t       p;
        int         i;
        g = ($urandom_range(0, 5) == 0) ? 3'd0 : pick_genotype(3'd0);
        typed_prev = g;
        p = pos_t'($urandom);
        push_marker(g, p, 1'b1);
        for (i = 1; i < len; i++) begin
            g = pick_genotype(typed_prev);
            if (g != 3'd0)
                typed_prev = g;
            if ($urandom_range(0, 9) == 0)
                p = pos_t'($urandom);
            else
                p = p + pos_t'($urandom_range(0, 3000));
            // rarely a first marker lands mid-individual, which breaks the run
            push_marker(g, p, $urandom_range(0, 49) == 0);
        end
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = queued_cnt + count;
        while (queued_cnt < stop_at) begin
            if ($urandom_range(0, 19) == 0)
                push_marker(3'($urandom), pos_t'($urandom), 1'($urandom));
            else
                gen_individual($urandom_range(2, 40));
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of cross_type: backcross rule
        check_cross_type();

        // directed, backcross: stream starts without a first marker
        push_marker(3'd0, 24'h000000, 1'b0);   // untyped, nothing known yet
        push_marker(3'd5, 24'h000010, 1'b0);   // first typed marker is only loaded
        push_marker(3'd0, 24'h000123, 1'b0);   // untyped marker only moves the index
        push_marker(3'd6, 24'h000100, 1'b0);   // change: crossover ordinal zero
        push_marker(3'd6, 24'h000200, 1'b0);
        push_marker(3'd7, 24'hFFFFFF, 1'b0);   // crossover with a typed count
        push_marker(3'd0, 24'hFFFFFF, 1'b1);   // new individual, untyped first marker
        push_marker(3'd3, 24'hFFFFFF, 1'b0);
        push_marker(3'd1, 24'h000000, 1'b0);   // widest interval, top down
        push_marker(3'd2, 24'hFFFFFF, 1'b0);
        wait_idle();

        // directed, intercross table
        write_reg(ADDR_CROSS_TYPE, 32'h0000_0001);
        check_cross_type();
        push_marker(3'd1, 24'h000000, 1'b1);
        push_marker(3'd3, 24'hFFFFFF, 1'b0);   // double crossover
        push_marker(3'd1, 24'hFFFFFF, 1'b0);   // double with equal flanks at the top
        push_marker(3'd2, 24'h001000, 1'b0);
        push_marker(3'd4, 24'h001100, 1'b0);   // no transition
        push_marker(3'd3, 24'h001200, 1'b0);
        push_marker(3'd4, 24'h001300, 1'b0);
        push_marker(3'd5, 24'h001400, 1'b0);   // no transition
        push_marker(3'd1, 24'h001500, 1'b0);
        push_marker(3'd5, 24'h001600, 1'b0);
        push_marker(3'd6, 24'h001700, 1'b0);   // code without a rule
        push_marker(3'd7, 24'h001800, 1'b0);
        push_marker(3'd3, 24'h001900, 1'b0);
        push_marker(3'd6, 24'h002000, 1'b1);   // remembered code without a rule
        push_marker(3'd1, 24'h002100, 1'b0);
        push_marker(3'd4, 24'h002200, 1'b1);
        push_marker(3'd3, 24'h002300, 1'b0);
        wait_idle();

        // a write to an unmapped address leaves the mode alone
        write_reg(ADDR_UNMAPPED, 32'h0000_0000);
        check_cross_type();

        // random phases across the modes; upper write bits carry no meaning
        write_reg(ADDR_CROSS_TYPE, 32'hFFFF_FFFE);
        check_cross_type();
        random_phase(450);
        wait_idle();

        write_reg(ADDR_CROSS_TYPE, 32'hFFFF_FFFF);
        check_cross_type();
        hold_req = 1'b1;   // receiver stalls while markers keep coming
        random_phase(450);
        wait_idle();

        write_reg(ADDR_CROSS_TYPE, 32'h0000_0000);
        check_cross_type();
        random_phase(300);
        wait_idle();

        // closing stretch without idling
        write_reg(ADDR_CROSS_TYPE, 32'h0000_0001);
        check_cross_type();
        calm = 1'b1;
        random_phase(300);
        wait_idle();
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);

        if (expected_crossovers.size() != 0)
            flag_error($sformatf("%0d beats never arrived", expected_crossovers.size()));
        $display("run covered %0d markers and %0d crossover beats in both cross types,",
            accepted_cnt, beats_checked);
        $display("with random idling and a long receiver hold-off; %0d errors", error_cnt);
        if (error_cnt == 0)
            $display("PASS crossover_locator_core");
        else
            $display("FAIL crossover_locator_core");
        $finish;
    end

endmodule
